/* src/dme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dme_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int SCALE_W             = 16;
    localparam int SCALE_FRAC          = 14;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_STRATEGY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER    = 2'd2;

    localparam int LOWER_RESET = -6553600;
    localparam int UPPER_RESET = 6553600;

    typedef enum logic [2:0] {
        STR_RAND1          = 3'd0,
        STR_RAND2          = 3'd1,
        STR_BEST1          = 3'd2,
        STR_BEST2          = 3'd3,
        STR_CUR_TO_RAND1   = 3'd4,
        STR_CUR_TO_BEST1   = 3'd5,
        STR_CUR_TO_PBEST1  = 3'd6,
        STR_RAND_TO_PBEST1 = 3'd7
    } t_strategy;

endpackage

`default_nettype wire

/* src/dme_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module dme_pipe #(
    parameter int VALUE_WIDTH = dme_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [dme_pkg::SCALE_W-1:0]     i_scale,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_target,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_best,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pbest,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pick1,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pick2,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pick3,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pick4,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_pick5,
    input  wire logic                            i_last,
    input  wire dme_pkg::t_strategy              i_strategy,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_lower,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_upper,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [VALUE_WIDTH-1:0]               o_value,
    output logic                                 o_repaired,
    output logic                                 o_last
);
    import dme_pkg::*;

    localparam int NSTAGE = 5;
    localparam int DW     = VALUE_WIDTH + 1;        // exact difference
    localparam int PW     = DW + SCALE_W + 1;       // F * difference
    localparam int AW     = VALUE_WIDTH + 20;       // accumulator
    localparam int VW     = AW - SCALE_FRAC;        // rounded, unsaturated value
    localparam logic signed [AW-1:0] ROUND = AW'(1) <<< (SCALE_FRAC - 1);
    localparam logic signed [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE:0]   adv;

    always_comb begin
        adv[NSTAGE] = i_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: strategy select and differences
    logic signed [VALUE_WIDTH-1:0] n_s1_base;
    logic signed [DW-1:0]          n_s1_d1, n_s1_d2;
    logic signed [VALUE_WIDTH-1:0] r_s1_base, r_s1_t;
    logic signed [DW-1:0]          r_s1_d1, r_s1_d2;
    logic [SCALE_W-1:0]            r_s1_f;
    logic                          r_s1_last;

    always_comb begin
        n_s1_base = i_pick1;
        n_s1_d1   = DW'(i_pick2) - DW'(i_pick3);
        n_s1_d2   = '0;
        case (i_strategy)
            STR_RAND1: begin
                n_s1_base = i_pick1;
                n_s1_d1   = DW'(i_pick2) - DW'(i_pick3);
                n_s1_d2   = '0;
            end
            STR_RAND2: begin
                n_s1_base = i_pick1;
                n_s1_d1   = DW'(i_pick2) - DW'(i_pick3);
                n_s1_d2   = DW'(i_pick4) - DW'(i_pick5);
            end
            STR_BEST1: begin
                n_s1_base = i_best;
                n_s1_d1   = DW'(i_pick1) - DW'(i_pick2);
                n_s1_d2   = '0;
            end
            STR_BEST2: begin
                n_s1_base = i_best;
                n_s1_d1   = DW'(i_pick1) - DW'(i_pick2);
                n_s1_d2   = DW'(i_pick3) - DW'(i_pick4);
            end
            STR_CUR_TO_RAND1: begin
                n_s1_base = i_target;
                n_s1_d1   = DW'(i_pick1) - DW'(i_target);
                n_s1_d2   = DW'(i_pick2) - DW'(i_pick3);
            end
            STR_CUR_TO_BEST1: begin
                n_s1_base = i_target;
                n_s1_d1   = DW'(i_best) - DW'(i_target);
                n_s1_d2   = DW'(i_pick1) - DW'(i_pick2);
            end
            STR_CUR_TO_PBEST1: begin
                n_s1_base = i_target;
                n_s1_d1   = DW'(i_pbest) - DW'(i_target);
                n_s1_d2   = DW'(i_pick1) - DW'(i_pick2);
            end
            STR_RAND_TO_PBEST1: begin
                n_s1_base = i_pick1;
                n_s1_d1   = DW'(i_pbest) - DW'(i_pick1);
                n_s1_d2   = DW'(i_pick2) - DW'(i_pick3);
            end
            default: begin
                n_s1_base = i_pick1;
                n_s1_d1   = DW'(i_pick2) - DW'(i_pick3);
                n_s1_d2   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_base <= n_s1_base;
            r_s1_d1   <= n_s1_d1;
            r_s1_d2   <= n_s1_d2;
            r_s1_f    <= i_scale;
            r_s1_t    <= i_target;
            r_s1_last <= i_last;
        end
    end

    // stage 2: scale both differences
    logic signed [SCALE_W:0]       s1_f_signed;
    logic signed [PW-1:0]          n_s2_m1, n_s2_m2;
    logic signed [PW-1:0]          r_s2_m1, r_s2_m2;
    logic signed [VALUE_WIDTH-1:0] r_s2_base, r_s2_t;
    logic                          r_s2_last;

    assign s1_f_signed = $signed({1'b0, r_s1_f});
    assign n_s2_m1     = s1_f_signed * r_s1_d1;
    assign n_s2_m2     = s1_f_signed * r_s1_d2;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_m1   <= n_s2_m1;
            r_s2_m2   <= n_s2_m2;
            r_s2_base <= r_s1_base;
            r_s2_t    <= r_s1_t;
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: sum, round half up, drop fraction bits of F
    logic signed [AW-1:0]          n_s3_acc;
    logic signed [VW-1:0]          r_s3_v;
    logic signed [VALUE_WIDTH-1:0] r_s3_t;
    logic                          r_s3_last;

    assign n_s3_acc = (AW'(r_s2_base) <<< SCALE_FRAC) + AW'(r_s2_m1) + AW'(r_s2_m2) + ROUND;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_v    <= n_s3_acc[AW-1:SCALE_FRAC];
            r_s3_t    <= r_s2_t;
            r_s3_last <= r_s2_last;
        end
    end

    // stage 4: bounce back off the lower bound
    logic signed [VALUE_WIDTH:0]   lo_sum;
    logic signed [VW-1:0]          n_s4_v;
    logic                          n_s4_rep;
    logic signed [VW-1:0]          r_s4_v;
    logic signed [VALUE_WIDTH-1:0] r_s4_t;
    logic                          r_s4_rep, r_s4_last;

    assign lo_sum = (VALUE_WIDTH+1)'(i_lower) + (VALUE_WIDTH+1)'(r_s3_t);

    always_comb begin
        n_s4_v   = r_s3_v;
        n_s4_rep = 1'b0;
        if (r_s3_v < VW'(i_lower)) begin
            n_s4_v   = VW'($signed(lo_sum[VALUE_WIDTH:1]));
            n_s4_rep = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_v    <= n_s4_v;
            r_s4_rep  <= n_s4_rep;
            r_s4_t    <= r_s3_t;
            r_s4_last <= r_s3_last;
        end
    end

    // stage 5: bounce back off the upper bound, saturate
    logic signed [VALUE_WIDTH:0]   hi_sum;
    logic signed [VW-1:0]          up_v;
    logic                          up_rep;
    logic signed [VALUE_WIDTH-1:0] n_s5_v;
    logic signed [VALUE_WIDTH-1:0] r_s5_v;
    logic                          r_s5_rep, r_s5_last;

    assign hi_sum = (VALUE_WIDTH+1)'(i_upper) + (VALUE_WIDTH+1)'(r_s4_t);

    always_comb begin
        up_v   = r_s4_v;
        up_rep = r_s4_rep;
        if (r_s4_v > VW'(i_upper)) begin
            up_v   = VW'($signed(hi_sum[VALUE_WIDTH:1]));
            up_rep = 1'b1;
        end
        if (up_v > VW'(MAX_VAL)) begin
            n_s5_v = MAX_VAL;
        end else if (up_v < VW'(MIN_VAL)) begin
            n_s5_v = MIN_VAL;
        end else begin
            n_s5_v = up_v[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_v    <= n_s5_v;
            r_s5_rep  <= up_rep;
            r_s5_last <= r_s4_last;
        end
    end

    assign o_valid    = r_vld[NSTAGE-1];
    assign o_value    = r_s5_v;
    assign o_repaired = r_s5_rep;
    assign o_last     = r_s5_last;

`ifndef SYNTH
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted beat did not enter stage 1");

    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !adv[3]) |=> (r_vld[2] && $stable(r_s3_v)))
        else $error("stage 3 lost or changed a held beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

/* src/de_mutant_element.sv */
`timescale 1ns / 1ps
`default_nettype none

// Differential evolution mutant element, one element per beat.
// Input stream (s_axis): tdata carries F and the target, best, p-best and five
// picked elements of one vector position; tlast marks the last element.
// Output stream (m_axis): tdata is the repaired mutant element, tuser is set
// when bounce-back repair moved it, tlast echoes the input marker.
// Config channel: index 0 strategy, 1 lower bound, 2 upper bound; always
// ready, write only while the stream is drained. Other indexes are ignored.
// Throughput: one beat per cycle while m_axis_tready is high; the five register
// stages are select and subtract, two 16-bit-by-value multiplies, sum and
// round, lower bound repair, upper bound repair with saturation.
// Reset: synchronous, clears all stage valids; strategy returns to rand1 and
// bounds to -100.0 / +100.0.
// Stall: a low m_axis_tready holds the output beat; bubbles further up still
// fill, and s_axis_tready drops only once every stage holds a beat.
module de_mutant_element #(
    parameter int VALUE_WIDTH = dme_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dme_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]              i_cfg_data,
    // input stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // scale_factor, target_value, best_value, pbest_value, first_pick,
    // second_pick, third_pick, fourth_pick, fifth_pick
    input  wire logic [dme_pkg::SCALE_W+8*VALUE_WIDTH-1:0] i_s_axis_tdata,
    input  wire logic                                i_s_axis_tlast,  // last_element
    // output stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // mutant_value, zero padded to bytes
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]         o_m_axis_tdata,
    output logic                                     o_m_axis_tuser,  // was_repaired
    output logic                                     o_m_axis_tlast   // is_last
);
    import dme_pkg::*;

    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int V0    = SCALE_W;

    t_strategy                     r_strategy;
    logic signed [VALUE_WIDTH-1:0] r_lower, r_upper;
    logic [VALUE_WIDTH-1:0]        value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STR_RAND1;
            r_lower    <= VALUE_WIDTH'(LOWER_RESET);
            r_upper    <= VALUE_WIDTH'(UPPER_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STRATEGY: r_strategy <= t_strategy'(i_cfg_data[2:0]);
                REG_LOWER:    r_lower    <= i_cfg_data;
                REG_UPPER:    r_upper    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dme_pipe #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_scale    (i_s_axis_tdata[SCALE_W-1:0]),
        .i_target   (i_s_axis_tdata[V0 + 0*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_best     (i_s_axis_tdata[V0 + 1*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pbest    (i_s_axis_tdata[V0 + 2*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pick1    (i_s_axis_tdata[V0 + 3*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pick2    (i_s_axis_tdata[V0 + 4*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pick3    (i_s_axis_tdata[V0 + 5*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pick4    (i_s_axis_tdata[V0 + 6*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_pick5    (i_s_axis_tdata[V0 + 7*VALUE_WIDTH +: VALUE_WIDTH]),
        .i_last     (i_s_axis_tlast),
        .i_strategy (r_strategy),
        .i_lower    (r_lower),
        .i_upper    (r_upper),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_value    (value),
        .o_repaired (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'(value);

endmodule

`default_nettype wire
